[rtl/pe_pkg.sv]
// ----------------------------------------------------------------------------
// Palette extractor package
// Sizes and the word type that travels down the cell chain.
// ----------------------------------------------------------------------------
package pe_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
	localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
	localparam int RGB_W           = 24;
	localparam int ARGB_W          = 32;
	localparam int RIDX_W          = 8;
	localparam int OIDX_W          = 8;
	localparam int OCNT_W          = 9;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// One word in flight along the chain. For a read, color starts at zero and
	// picks up the stored entry at the cell whose index matches.
	typedef struct packed {
		logic              vld;
		logic              rd;
		logic [RGB_W-1:0]  color;
		logic              last;
		logic [RIDX_W-1:0] ridx;
		logic              clr;
		logic              done;
		logic              hit;
		logic              added;
		logic [IDX_W-1:0]  idx;
	} pe_tok_t;

endpackage

[rtl/pe_cell.sv]
// ----------------------------------------------------------------------------
// Palette cell
// Holds one palette entry, matches, appends or reads it for the passing word.
// ----------------------------------------------------------------------------
module pe_cell import pe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [IDX_W-1:0] cell_index,
	input  pe_tok_t          tok_in,
	output pe_tok_t          tok_out
);

	logic             valid_q;
	logic [RGB_W-1:0] color_q;
	pe_tok_t          tok_q;

	logic    pix;
	logic    live;
	logic    open;
	logic    match;
	logic    take;
	logic    rd_hit;
	pe_tok_t nxt;

	always_comb begin
		pix  = tok_in.vld && (tok_in.rd == OP_PIXEL);
		// A pixel that opens a new image empties every cell it passes.
		live = valid_q && !(pix && tok_in.clr);
		open = pix && !tok_in.hit && !tok_in.added;
		match = open && live && (color_q == tok_in.color);
		take  = open && !live;
		rd_hit = tok_in.vld && (tok_in.rd == OP_READ) && live
			&& ({{IDX_W{1'b0}}, tok_in.ridx} == {{RIDX_W{1'b0}}, cell_index});
		nxt = tok_in;
		if (match || take) begin
			nxt.idx = cell_index;
		end
		if (match) begin
			nxt.hit = 1'b1;
		end
		if (take) begin
			nxt.added = 1'b1;
		end
		if (rd_hit) begin
			nxt.hit   = 1'b1;
			nxt.color = color_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			tok_q.vld <= 1'b0;
		end else if (advance) begin
			valid_q <= live || take;
			tok_q   <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && take) begin
			color_q <= tok_in.color;
		end
	end

	assign tok_out = tok_q;

endmodule

[rtl/pe_tail.sv]
// ----------------------------------------------------------------------------
// Palette tail stage
// Keeps the color count and overflow flag and registers the result word.
// ----------------------------------------------------------------------------
module pe_tail import pe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  pe_tok_t           tok_in,
	output logic              out_valid,
	output logic [OIDX_W-1:0] entry_index,
	output logic              was_found,
	output logic              was_added,
	output logic              overflowed,
	output logic [OCNT_W-1:0] color_count,
	output logic [RGB_W-1:0]  entry_color,
	output logic              image_complete
);

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             out_valid_q;
	logic [OIDX_W-1:0] entry_index_q;
	logic             was_found_q;
	logic             was_added_q;
	logic             overflowed_q;
	logic [OCNT_W-1:0] color_count_q;
	logic [RGB_W-1:0] entry_color_q;
	logic             image_complete_q;

	logic               pix;
	logic [CNT_W-1:0]   cnt_base;
	logic               ovf_base;
	logic [CNT_W-1:0]   cnt_nxt;
	logic               ovf_nxt;
	logic               found_o;
	logic               added_o;
	logic [IDX_W+7:0]   idx_ext;
	logic [CNT_W+8:0]   cnt_ext;
	logic [OIDX_W-1:0]  index_o;

	always_comb begin
		pix      = tok_in.vld && (tok_in.rd == OP_PIXEL);
		cnt_base = (pix && tok_in.clr) ? '0 : count_q;
		ovf_base = (pix && tok_in.clr) ? 1'b0 : ovf_q;
		cnt_nxt  = cnt_base;
		ovf_nxt  = ovf_base;
		found_o  = pix && !ovf_base && tok_in.hit;
		added_o  = pix && !ovf_base && tok_in.added;
		if (added_o) begin
			cnt_nxt = cnt_base + CNT_W'(1);
		end else if (pix && !ovf_base && !tok_in.hit) begin
			// Unmatched and no cell left open: the palette is full.
			ovf_nxt = 1'b1;
		end
		idx_ext = {8'b0, tok_in.idx};
		cnt_ext = ovf_nxt ? '0 : {9'b0, cnt_nxt};
		if (!pix) begin
			index_o = tok_in.ridx;
		end else if (found_o || added_o) begin
			index_o = idx_ext[OIDX_W-1:0];
		end else begin
			index_o = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= tok_in.vld;
			if (tok_in.vld) begin
				count_q <= cnt_nxt;
				ovf_q   <= ovf_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			entry_index_q    <= index_o;
			was_found_q      <= found_o;
			was_added_q      <= added_o;
			overflowed_q     <= ovf_nxt;
			color_count_q    <= cnt_ext[OCNT_W-1:0];
			entry_color_q    <= tok_in.color;
			image_complete_q <= pix ? tok_in.last : tok_in.done;
		end
	end

	assign out_valid      = out_valid_q;
	assign entry_index    = entry_index_q;
	assign was_found      = was_found_q;
	assign was_added      = was_added_q;
	assign overflowed     = overflowed_q;
	assign color_count    = color_count_q;
	assign entry_color    = entry_color_q;
	assign image_complete = image_complete_q;

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == CNT_W'(PALETTE_ENTRIES)))
		else $error("overflow flag set with palette not full");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(PALETTE_ENTRIES))
		else $error("color count beyond palette size");

	a_hit_add: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && tok_in.vld) |-> !(tok_in.hit && tok_in.added))
		else $error("word both matched and appended");

endmodule

[rtl/palette_extractor.sv]
// ----------------------------------------------------------------------------
// Palette extractor
// Builds a palette of distinct RGB colors from a pixel stream.
// ----------------------------------------------------------------------------
// Input words carry either a pixel (operation 0) or a palette read
// (operation 1). A word is taken when in_valid is high and in_stall is low;
// results leave the same way on out_valid / out_stall, one result word for
// every input word, in order.
// Each word walks a chain of PALETTE_ENTRIES cells, one cell per cycle while
// not frozen; each cell holds one entry, compares, appends or reads it, and
// registers the word; the tail registers the result. Unless frozen, the chain
// takes a new word every cycle, so throughput is one word per cycle.
// When the output register holds an untaken result and out_stall is high the
// whole chain freezes and in_stall goes high until the result is taken.
// Reset empties every cell, clears the count, overflow and image-done flags,
// and drops any words in flight. A pixel that follows the last pixel of an
// image clears the palette as it passes through the cells.
// ----------------------------------------------------------------------------
module palette_extractor import pe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [ARGB_W-1:0] pixel_argb,
	input  logic              last_pixel,
	input  logic [RIDX_W-1:0] read_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [OIDX_W-1:0] entry_index,
	output logic              was_found,
	output logic              was_added,
	output logic              overflowed,
	output logic [OCNT_W-1:0] color_count,
	output logic [RGB_W-1:0]  entry_color,
	output logic              image_complete
);

	logic    done_q;
	logic    advance;
	pe_tok_t chain [PALETTE_ENTRIES+1];

	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;

	always_comb begin
		chain[0]       = '0;
		chain[0].vld   = in_valid;
		chain[0].rd    = operation;
		chain[0].color = (operation == OP_READ) ? '0 : pixel_argb[RGB_W-1:0];
		chain[0].last  = last_pixel;
		chain[0].ridx  = read_index;
		chain[0].clr   = (operation == OP_PIXEL) && done_q;
		chain[0].done  = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (in_valid && advance && (operation == OP_PIXEL)) begin
			done_q <= last_pixel;
		end
	end

	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
		pe_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.advance    (advance),
			.cell_index (IDX_W'(i)),
			.tok_in     (chain[i]),
			.tok_out    (chain[i+1])
		);
	end

	pe_tail u_tail (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.tok_in         (chain[PALETTE_ENTRIES]),
		.out_valid      (out_valid),
		.entry_index    (entry_index),
		.was_found      (was_found),
		.was_added      (was_added),
		.overflowed     (overflowed),
		.color_count    (color_count),
		.entry_color    (entry_color),
		.image_complete (image_complete)
	);

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with the output register free");

endmodule

[bench/palette_extractor_tb.sv]
// ----------------------------------------------------------------------------
// Palette extractor testbench
// Streams directed and random pixel and read words into the palette
// extractor, predicts each result word in order, and checks every field.
// ----------------------------------------------------------------------------
module palette_extractor_tb;
	import pe_pkg::*;

	localparam int PIPE_LATENCY = PALETTE_ENTRIES + 1;
	localparam int RANDOM_WORDS = 1600;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct {
		logic              operation;
		logic [ARGB_W-1:0] pixel_argb;
		logic              last_pixel;
		logic [RIDX_W-1:0] read_index;
		bit                drain_first;
	} pixel_word_t;

	typedef struct packed {
		logic [OIDX_W-1:0] entry_index;
		logic              was_found;
		logic              was_added;
		logic              overflowed;
		logic [OCNT_W-1:0] color_count;
		logic [RGB_W-1:0]  entry_color;
		logic              image_complete;
	} palette_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              operation = OP_PIXEL;
	logic [ARGB_W-1:0] pixel_argb = '0;
	logic              last_pixel = 1'b0;
	logic [RIDX_W-1:0] read_index = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [OIDX_W-1:0] entry_index;
	logic              was_found;
	logic              was_added;
	logic              overflowed;
	logic [OCNT_W-1:0] color_count;
	logic [RGB_W-1:0]  entry_color;
	logic              image_complete;

	palette_extractor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.pixel_argb     (pixel_argb),
		.last_pixel     (last_pixel),
		.read_index     (read_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.entry_index    (entry_index),
		.was_found      (was_found),
		.was_added      (was_added),
		.overflowed     (overflowed),
		.color_count    (color_count),
		.entry_color    (entry_color),
		.image_complete (image_complete)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predicted palette contents and flags.
	logic [RGB_W-1:0] pal_mem [PALETTE_ENTRIES];
	int               pal_count = 0;
	bit               pal_ovf = 1'b0;
	bit               pal_done = 1'b0;

	pixel_word_t     pixel_words_q[$];
	palette_result_t palette_results_q[$];
	pixel_word_t     bus_word;
	bit              hold_next = 1'b0;
	int              total_words = 1;
	int              load_cnt = 0;
	int              idle_phase = 0;
	int              accepted_cnt = 0;
	int              result_cnt = 0;
	int              cycle_cnt = 0;
	int              errors = 0;
	int              pixels_taken = 0;
	int              reads_taken = 0;
	int              ovf_events = 0;
	int              images_ended = 0;

	function automatic palette_result_t next_palette_result(input pixel_word_t w);
		palette_result_t  r;
		logic [RGB_W-1:0] rgb;
		int               idx;
		bit               hit;
		r = '0;
		idx = 0;
		hit = 1'b0;
		rgb = w.pixel_argb[RGB_W-1:0];
		if (w.operation == OP_READ) begin
			r.entry_index = w.read_index;
			if (int'(w.read_index) < pal_count && int'(w.read_index) < PALETTE_ENTRIES)
				r.entry_color = pal_mem[w.read_index];
			r.image_complete = pal_done;
		end else begin
			if (pal_done) begin
				pal_count = 0;
				pal_ovf = 1'b0;
				pal_done = 1'b0;
			end
			if (!pal_ovf) begin
				for (int i = 0; i < pal_count && !hit; i++) begin
					if (pal_mem[i] == rgb) begin
						hit = 1'b1;
						idx = i;
					end
				end
				if (!hit) begin
					if (pal_count >= PALETTE_ENTRIES) begin
						pal_ovf = 1'b1;
						ovf_events++;
					end else begin
						idx = pal_count;
						pal_mem[pal_count] = rgb;
						pal_count++;
						r.was_added = 1'b1;
					end
				end
			end
			if (w.last_pixel) begin
				pal_done = 1'b1;
				images_ended++;
			end
			r.entry_index = OIDX_W'(idx);
			r.was_found = hit;
			r.entry_color = rgb;
			r.image_complete = w.last_pixel;
		end
		r.overflowed = pal_ovf;
		r.color_count = pal_ovf ? '0 : OCNT_W'(pal_count);
		return r;
	endfunction

	function automatic int send_idle_pct(input int ph);
		return (ph == 0) ? 24 : (ph == 1) ? 74 : 0;
	endfunction

	function automatic int recv_idle_pct(input int ph);
		return (ph == 0) ? 74 : (ph == 1) ? 24 : 0;
	endfunction

	function automatic logic [RIDX_W-1:0] pick_read_index();
		return ($urandom_range(1) == 0) ? RIDX_W'($urandom_range(63))
			: RIDX_W'($urandom_range(255));
	endfunction

	task automatic add_word(input logic op, input logic [ARGB_W-1:0] argb,
			input logic eop, input logic [RIDX_W-1:0] ridx);
		pixel_word_t w;
		w.operation = op;
		w.pixel_argb = argb;
		w.last_pixel = eop;
		w.read_index = ridx;
		w.drain_first = hold_next;
		hold_next = 1'b0;
		pixel_words_q.push_back(w);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
			errors++;
		end
	endtask

	// Driver: presents the oldest pending word and holds it until it is taken.
	always @(posedge clk) begin
		bit took;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			took = in_valid && !in_stall;
			if (took) begin
				palette_results_q.push_back(next_palette_result(bus_word));
				accepted_cnt <= accepted_cnt + 1;
				if (bus_word.operation == OP_READ)
					reads_taken++;
				else
					pixels_taken++;
			end
			if (in_valid && !took) begin
				// Stalled: the word stays on the bus unchanged.
			end else if (pixel_words_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pixel_words_q[0].drain_first &&
					result_cnt != accepted_cnt + int'(took)) begin
				in_valid <= 1'b0;
			end else if ($urandom_range(99) < send_idle_pct(idle_phase)) begin
				in_valid <= 1'b0;
			end else begin
				bus_word = pixel_words_q.pop_front();
				load_cnt++;
				idle_phase <= (load_cnt * 3) / total_words;
				operation  <= bus_word.operation;
				pixel_argb <= bus_word.pixel_argb;
				last_pixel <= bus_word.last_pixel;
				read_index <= bus_word.read_index;
				in_valid   <= 1'b1;
			end
		end
	end

	// Monitor: compares each taken result word with the oldest prediction.
	always @(posedge clk) begin
		palette_result_t exp_res;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				result_cnt <= result_cnt + 1;
				if (palette_results_q.size() == 0) begin
					$error("result word with no prediction waiting");
					errors++;
				end else begin
					exp_res = palette_results_q.pop_front();
					check_field("entry_index", 32'(exp_res.entry_index),
						32'(entry_index));
					check_field("was_found", 32'(exp_res.was_found), 32'(was_found));
					check_field("was_added", 32'(exp_res.was_added), 32'(was_added));
					check_field("overflowed", 32'(exp_res.overflowed),
						32'(overflowed));
					check_field("color_count", 32'(exp_res.color_count),
						32'(color_count));
					check_field("entry_color", 32'(exp_res.entry_color),
						32'(entry_color));
					check_field("image_complete", 32'(exp_res.image_complete),
						32'(image_complete));
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct(idle_phase));
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [ARGB_W-1:0] pool [0:299];
		logic [ARGB_W-1:0] argb;
		logic [31:0]       tmp;
		logic [RGB_W-1:0]  base;
		logic              eop;
		bit                big;
		int                directed_cnt;
		int                img;
		int                n;
		int                npix;
		int                ptr;
		int                k;

		// Reads of an empty palette at both ends of the index range.
		add_word(OP_READ, 32'h0, 1'b0, 8'd0);
		add_word(OP_READ, 32'hFFFF_FFFF, 1'b1, 8'd255);
		// Extreme colors, then the same colors with a different alpha byte.
		add_word(OP_PIXEL, 32'h0000_0000, 1'b0, 8'd255);
		add_word(OP_PIXEL, 32'hFFFF_FFFF, 1'b0, 8'd0);
		add_word(OP_PIXEL, 32'hFF00_0000, 1'b0, 8'd17);
		add_word(OP_PIXEL, 32'h00FF_FFFF, 1'b0, 8'd200);
		add_word(OP_PIXEL, 32'h5A12_3456, 1'b0, 8'd1);
		add_word(OP_PIXEL, 32'hA5ED_CBA9, 1'b0, 8'd2);
		for (int i = 0; i < 5; i++)
			add_word(OP_READ, $urandom, 1'($urandom_range(1)), RIDX_W'(i));
		// End of image on a color already held, then reads of the done image.
		add_word(OP_PIXEL, 32'h0012_3456, 1'b1, 8'd0);
		add_word(OP_READ, 32'h0, 1'b0, 8'd2);
		add_word(OP_READ, 32'h0, 1'b0, 8'd255);
		// The next pixel starts a fresh palette.
		add_word(OP_PIXEL, 32'h00AB_CDEF, 1'b0, 8'd9);
		add_word(OP_READ, 32'h0, 1'b0, 8'd1);
		add_word(OP_READ, 32'h0, 1'b0, 8'd0);
		// Two image ends in a row; the second image holds a single pixel.
		add_word(OP_PIXEL, 32'h1234_5678, 1'b1, 8'd3);
		add_word(OP_PIXEL, 32'h1234_5678, 1'b1, 8'd4);
		add_word(OP_READ, 32'h0, 1'b0, 8'd0);
		directed_cnt = pixel_words_q.size();

		img = 0;
		hold_next = 1'b1;
		while (pixel_words_q.size() < directed_cnt + RANDOM_WORDS) begin
			big = (img % 25 == 2);
			if (big) begin
				// More distinct colors than the palette holds.
				hold_next = 1'b1;
				n = $urandom_range(257, 272);
				tmp = $urandom;
				base = {tmp[14:0], 9'd0};
				for (int i = 0; i < n; i++) begin
					tmp = $urandom;
					pool[i] = {tmp[7:0], base | RGB_W'(i)};
				end
				npix = n + $urandom_range(4, 16);
			end else begin
				n = $urandom_range(1, 48);
				for (int i = 0; i < n; i++)
					pool[i] = $urandom;
				npix = $urandom_range(1, 60);
			end
			ptr = 0;
			k = 0;
			while (k < npix) begin
				if ($urandom_range(9) == 0)
					add_word(OP_READ, $urandom, 1'($urandom_range(1)), pick_read_index());
				if (big && ptr < n && (ptr == 0 || $urandom_range(3) != 0)) begin
					argb = pool[ptr];
					ptr++;
				end else if ($urandom_range(7) == 0) begin
					argb = $urandom;
				end else begin
					argb = pool[$urandom_range(big ? ptr - 1 : n - 1)];
				end
				k++;
				// A large image runs on until every one of its colors has shown up.
				if (big && ptr < n && k == npix)
					npix++;
				if (k == npix)
					eop = ($urandom_range(9) != 0);
				else
					eop = !big && ($urandom_range(39) == 0);
				add_word(OP_PIXEL, argb, eop, RIDX_W'($urandom_range(255)));
			end
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 3))
					add_word(OP_READ, $urandom, 1'($urandom_range(1)), pick_read_index());
			end
			img++;
		end
		total_words = pixel_words_q.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pixel_words_q.size() != 0 || in_valid || result_cnt != accepted_cnt)
			@(negedge clk);
		repeat (2 * PIPE_LATENCY) @(negedge clk);
		if (palette_results_q.size() != 0) begin
			$error("%0d predicted result words never arrived", palette_results_q.size());
			errors++;
		end
		$display("Checked %0d pixel words and %0d palette reads over %0d image ends.",
			pixels_taken, reads_taken, images_ended);
		$display("Palette overflowed %0d times; %0d field mismatches seen.",
			ovf_events, errors);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
